>>> sv/deadline_sorted_timer_queue_unit_defines.svh
// Assertion macros for the timer queue.
// DSTQ_ASSERT checks outside reset, DSTQ_ASSERT_RST also during reset.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define DSTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSTQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSTQ_ASSERT(lbl, prop, msg)
`define DSTQ_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> sv/dstq_pkg.sv
package dstq_pkg;

  // field widths of the words
  localparam int NOW_W = 32;
  localparam int TMO_W = 31;
  localparam int TAG_W = 16;
  localparam int OCC_W = 5;
  localparam int DL_W  = 33;

  localparam logic [TMO_W-1:0] TTH_MAX = {TMO_W{1'b1}};

  // operation codes
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic             op;
    logic [NOW_W-1:0] now_ms;
    logic [TMO_W-1:0] timeout_ms;
    logic [TAG_W-1:0] entry_tag;
  } in_word_t;

  typedef struct packed {
    logic             popped;
    logic [TAG_W-1:0] popped_tag;
    logic             queue_empty;
    logic [TMO_W-1:0] time_to_head;
    logic             overflow;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

  // command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

endpackage

>>> sv/deadline_sorted_timer_queue_unit.sv
// Deadline-sorted timer queue.
// Input channel in_valid/in_stall/in_word: a put word (op = put) queues
// entry_tag with deadline now_ms + timeout_ms behind every entry due at the
// same time or earlier; a get word pops the head if it is due at now_ms.
// Result channel out_valid/out_stall/out_word: one word per input word,
// describing the queue after that step (popped tag, empty flag, time until
// the head is due, overflow on a put into a full queue, occupancy).
// Steps: each word is first registered and its deadline formed, then the
// row of cells compares against it and shifts in parallel.
// The result is written into the output register at the same edge as the
// shift, which is also when out_valid is set. The block takes no new word
// until the last one's result is loaded into the output register.
// Reset clears the entry count, the control state and the output
// valid flag; the cells keep whatever they hold and are never read before
// written. The block is ready right after reset.
// When the receiver stalls, the result waits in the output register; the
// block still takes the next word but holds it before the shift until the
// output register is free.
`include "deadline_sorted_timer_queue_unit_defines.svh"

module deadline_sorted_timer_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dstq_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dstq_pkg::out_word_t  out_word
);
  import dstq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t              state_r, state_nxt;
  in_word_t            item_r;
  logic [DL_W-1:0]     dl_new_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  out_word_t           out_r, out_nxt;
  logic                out_valid_r;

  logic                load;
  logic                is_put;
  logic                full;
  logic                do_ins;
  logic                do_pop;
  logic [DL_W-1:0]     head_nxt;
  logic [DL_W:0]       diff;
  logic [TAG_BITS-1:0] new_tag;
  cell_ctl_t           ctl;

  logic [DL_W-1:0]     cell_dl  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_mv;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // advance on accept, leave apply once the result is loaded
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // capture the word and form its deadline
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r   <= in_word;
      dl_new_r <= {1'b0, in_word.now_ms} + {2'b00, in_word.timeout_ms};
    end
  end

  assign is_put  = (item_r.op == OP_PUT);
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_ins  = load && is_put && !full;
  assign do_pop  = load && !is_put && (count_r != '0) &&
                   (cell_dl[0] <= {1'b0, item_r.now_ms});
  assign new_tag = TAG_BITS'(item_r.entry_tag);
  assign ctl     = '{ins: do_ins, pop: do_pop};

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                occ;
    logic                lmv;
    logic [DL_W-1:0]     ldl, rdl;
    logic [TAG_BITS-1:0] ltag, rtag;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lmv  = 1'b0;
      assign ldl  = cell_dl[0];
      assign ltag = cell_tag[0];
    end else begin : g_mid
      assign lmv  = cell_mv[i-1];
      assign ldl  = cell_dl[i-1];
      assign ltag = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rdl  = cell_dl[i];
      assign rtag = cell_tag[i];
    end else begin : g_inner
      assign rdl  = cell_dl[i+1];
      assign rtag = cell_tag[i+1];
    end

    dstq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ),
      .new_dl    (dl_new_r),
      .new_tag   (new_tag),
      .left_move (lmv),
      .left_dl   (ldl),
      .left_tag  (ltag),
      .right_dl  (rdl),
      .right_tag (rtag),
      .move      (cell_mv[i]),
      .dl        (cell_dl[i]),
      .tag       (cell_tag[i])
    );
  end

  // count and result word after the step
  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end

    head_nxt = cell_dl[0];
    if (do_ins && cell_mv[0]) begin
      head_nxt = dl_new_r;
    end else if (do_pop) begin
      head_nxt = cell_dl[1];
    end

    diff = {1'b0, head_nxt} - {2'b00, item_r.now_ms};

    out_nxt.popped      = do_pop;
    out_nxt.popped_tag  = do_pop ? TAG_W'(cell_tag[0]) : '0;
    out_nxt.queue_empty = (count_nxt == '0);
    out_nxt.overflow    = is_put && full;
    out_nxt.occupancy   = OCC_W'(count_nxt);
    if (count_nxt == '0 || diff[DL_W] || diff == '0) begin
      out_nxt.time_to_head = '0;
    end else if (|diff[DL_W-1:TMO_W]) begin
      out_nxt.time_to_head = TTH_MAX;
    end else begin
      out_nxt.time_to_head = diff[TMO_W-1:0];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  `DSTQ_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `DSTQ_ASSERT(a_accept_apply, in_valid && !in_stall |=> state_r == ST_APPLY, "accepted word not applied")
  `DSTQ_ASSERT(a_ovf_hold, load && is_put && full |=> count_r == $past(count_r), "dropped put changed queue")
  `DSTQ_ASSERT(a_pop_count, do_pop |=> count_r == $past(count_r) - CNT_W'(1), "pop did not shrink queue")
  `DSTQ_ASSERT_RST(a_reset_clear, !rst_n |=> count_r == '0 && !out_valid_r, "reset left queue state")

endmodule

>>> sv/dstq_cell.sv
module dstq_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                      clk,
  input  dstq_pkg::cell_ctl_t       ctl,
  input  logic                      occupied,
  input  logic [dstq_pkg::DL_W-1:0] new_dl,
  input  logic [TAG_BITS-1:0]       new_tag,
  input  logic                      left_move,
  input  logic [dstq_pkg::DL_W-1:0] left_dl,
  input  logic [TAG_BITS-1:0]       left_tag,
  input  logic [dstq_pkg::DL_W-1:0] right_dl,
  input  logic [TAG_BITS-1:0]       right_tag,
  output logic                      move,
  output logic [dstq_pkg::DL_W-1:0] dl,
  output logic [TAG_BITS-1:0]       tag
);
  import dstq_pkg::*;

  logic [DL_W-1:0]     dl_r;
  logic [TAG_BITS-1:0] tag_r;

  // cell sits at or behind the insert point unless it holds an earlier or equal deadline
  assign move = !(occupied && (dl_r <= new_dl));
  assign dl   = dl_r;
  assign tag  = tag_r;

  // take the new entry, shift from the left on insert, shift from the right on pop
  always_ff @(posedge clk) begin
    if (ctl.ins && move) begin
      if (left_move) begin
        dl_r  <= left_dl;
        tag_r <= left_tag;
      end else begin
        dl_r  <= new_dl;
        tag_r <= new_tag;
      end
    end else if (ctl.pop) begin
      dl_r  <= right_dl;
      tag_r <= right_tag;
    end
  end

endmodule

>>> sim/tb_deadline_sorted_timer_queue_unit.sv
`timescale 1ns / 100ps

module tb_deadline_sorted_timer_queue_unit;
  import dstq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TAG_BITS     = 16;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 100;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // shadow copy of the sorted queue
  logic [DL_W-1:0]  shadow_deadline [QUEUE_DEPTH];
  logic [TAG_W-1:0] shadow_tag      [QUEUE_DEPTH];
  int               shadow_count = 0;

  out_word_t pending_results[$];
  stim_row_t stim_rows[$];
  int        tail_start;
  int        mismatches  = 0;
  int        cycle_count = 0;
  int        stall_left  = 0;
  bit        calm        = 1'b0;

  deadline_sorted_timer_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one word to the shadow queue and return the word it should produce.
  function automatic out_word_t queue_step(in_word_t w);
    out_word_t       r;
    logic [DL_W-1:0] now33;
    logic [DL_W-1:0] dl;
    logic [DL_W-1:0] wait_ms;
    int              pos;
    r     = '0;
    now33 = {1'b0, w.now_ms};
    if (w.op == OP_PUT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        dl  = now33 + {2'b00, w.timeout_ms};
        pos = 0;
        while (pos < shadow_count && shadow_deadline[pos] <= dl) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_deadline[i] = shadow_deadline[i-1];
          shadow_tag[i]      = shadow_tag[i-1];
        end
        shadow_deadline[pos] = dl;
        shadow_tag[pos]      = w.entry_tag;
        shadow_count++;
      end
    end else if (shadow_count > 0 && shadow_deadline[0] <= now33) begin
      r.popped     = 1'b1;
      r.popped_tag = shadow_tag[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_deadline[i-1] = shadow_deadline[i];
        shadow_tag[i-1]      = shadow_tag[i];
      end
      shadow_count--;
    end
    r.queue_empty = (shadow_count == 0);
    if (shadow_count > 0 && shadow_deadline[0] > now33) begin
      wait_ms = shadow_deadline[0] - now33;
      r.time_to_head = (wait_ms > {2'b00, TTH_MAX}) ? TTH_MAX : wait_ms[TMO_W-1:0];
    end
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic in_word_t mk_in(logic op, logic [NOW_W-1:0] now,
                                     logic [TMO_W-1:0] tmo, logic [TAG_W-1:0] tag);
    in_word_t w;
    w.op         = op;
    w.now_ms     = now;
    w.timeout_ms = tmo;
    w.entry_tag  = tag;
    return w;
  endfunction

  function automatic out_word_t mk_out(logic popped, logic [TAG_W-1:0] ptag, logic empty,
                                       logic [TMO_W-1:0] tth, logic ovf,
                                       logic [OCC_W-1:0] occ);
    out_word_t r;
    r.popped       = popped;
    r.popped_tag   = ptag;
    r.queue_empty  = empty;
    r.time_to_head = tth;
    r.overflow     = ovf;
    r.occupancy    = occ;
    return r;
  endfunction

  function automatic void add_row(in_word_t w, bit typed, out_word_t want);
    stim_row_t s;
    s.word  = w;
    s.typed = typed;
    s.want  = want;
    stim_rows.push_back(s);
  endfunction

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Send one word; on acceptance log what it should produce.
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    int        gap;
    out_word_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    r = queue_step(w);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic walk_rows(int first, int last);
    for (int i = first; i < last; i++)
      send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
  endtask

  // Hold the sender until every outstanding result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // Result side: check each accepted word and draw the next stall.
  always @(posedge clk) begin
    out_word_t want;
    int        n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_word.popped_tag), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_word.popped !== want.popped)
          report_mismatch("popped", 32'(out_word.popped), 32'(want.popped));
        if (out_word.popped_tag !== want.popped_tag)
          report_mismatch("popped_tag", 32'(out_word.popped_tag), 32'(want.popped_tag));
        if (out_word.queue_empty !== want.queue_empty)
          report_mismatch("queue_empty", 32'(out_word.queue_empty), 32'(want.queue_empty));
        if (out_word.time_to_head !== want.time_to_head)
          report_mismatch("time_to_head", 32'(out_word.time_to_head),
                          32'(want.time_to_head));
        if (out_word.overflow !== want.overflow)
          report_mismatch("overflow", 32'(out_word.overflow), 32'(want.overflow));
        if (out_word.occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(out_word.occupancy), 32'(want.occupancy));
      end
      n = pick_gap();
      if (n > 0) out_stall <= 1'b1;
      stall_left <= n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_deadline_sorted_timer_queue_unit failed");
      $finish;
    end
  end

  initial begin
    logic [NOW_W-1:0] now_ms;
    logic [DL_W-1:0]  sum;
    logic [TMO_W-1:0] tmo;
    logic             op;
    int               put_pct;
    int               r;

    // Directed rows: empty queue, extremes of time, backwards time, ties.
    add_row(mk_in(OP_GET, 32'h0, '0, '0), 1, mk_out(0, 0, 1, 0, 0, 0));
    add_row(mk_in(OP_PUT, 32'h0, TTH_MAX, 16'hFFFF), 1, mk_out(0, 0, 0, TTH_MAX, 0, 1));
    add_row(mk_in(OP_GET, 32'h0, TTH_MAX, 16'hFFFF), 1, mk_out(0, 0, 0, TTH_MAX, 0, 1));
    add_row(mk_in(OP_GET, 32'hFFFF_FFFF, '0, '0), 1, mk_out(1, 16'hFFFF, 1, 0, 0, 0));
    add_row(mk_in(OP_PUT, 32'hFFFF_FFF0, 31'hF, '0), 1, mk_out(0, 0, 0, 31'hF, 0, 1));
    add_row(mk_in(OP_GET, 32'h0, '0, '0), 1, mk_out(0, 0, 0, TTH_MAX, 0, 1));
    add_row(mk_in(OP_GET, 32'hFFFF_FFFE, '0, '0), 1, mk_out(0, 0, 0, 31'h1, 0, 1));
    add_row(mk_in(OP_GET, 32'hFFFF_FFFF, '0, '0), 1, mk_out(1, 0, 1, 0, 0, 0));
    add_row(mk_in(OP_GET, 32'hFFFF_FFFF, '0, '0), 1, mk_out(0, 0, 1, 0, 0, 0));
    add_row(mk_in(OP_PUT, 32'd100, 31'd5, 16'hA5A5), 0, '0);
    add_row(mk_in(OP_PUT, 32'd102, 31'd3, 16'h5A5A), 0, '0);
    add_row(mk_in(OP_PUT, 32'd102, 31'd0, 16'h1234), 0, '0);
    add_row(mk_in(OP_PUT, 32'd102, TTH_MAX, 16'hFFFF), 0, '0);
    add_row(mk_in(OP_GET, 32'd101, '0, '0), 0, '0);
    add_row(mk_in(OP_GET, 32'd104, '0, '0), 0, '0);
    add_row(mk_in(OP_GET, 32'd105, '0, '0), 0, '0);
    add_row(mk_in(OP_GET, 32'd105, '0, '0), 0, '0);
    add_row(mk_in(OP_GET, 32'd105, '0, '0), 0, '0);
    add_row(mk_in(OP_GET, 32'h8000_0065, '0, '0), 0, '0);
    add_row(mk_in(OP_GET, 32'h8000_0065, '0, '0), 0, '0);
    tail_start = stim_rows.size();
    // Tail rows run on an empty queue: a deadline past the 32-bit range stays put.
    add_row(mk_in(OP_PUT, 32'hFFFF_FFFF, TTH_MAX, 16'hC33C), 1, mk_out(0, 0, 0, TTH_MAX, 0, 1));
    add_row(mk_in(OP_GET, 32'hFFFF_FFFF, '0, '0), 1, mk_out(0, 0, 0, TTH_MAX, 0, 1));
    add_row(mk_in(OP_PUT, 32'h0, '0, 16'h0001), 1, mk_out(0, 0, 0, 0, 0, 2));
    add_row(mk_in(OP_GET, 32'h0, '0, '0), 1, mk_out(1, 16'h0001, 0, TTH_MAX, 0, 1));

    // Hold reset, then release.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    walk_rows(0, tail_start);

    // Random phases: fill-heavy, drain-heavy and balanced, some without idling.
    now_ms  = 32'd1000;
    put_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        r       = $urandom_range(0, 2);
        put_pct = (r == 0) ? 80 : (r == 1) ? 20 : 50;
        calm    = ((n / 60) % 4 == 3);
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();

      // Advance time, with rare steps back and jumps.
      r = $urandom_range(0, 99);
      if (r < 88) begin
        sum    = {1'b0, now_ms} + DL_W'($urandom_range(0, 20));
        now_ms = sum[DL_W-1] ? 32'hFFFF_FFFF : sum[NOW_W-1:0];
      end else if (r < 94) begin
        r      = $urandom_range(0, 50);
        now_ms = (now_ms > NOW_W'(r)) ? now_ms - NOW_W'(r) : 32'h0;
      end else if (r < 97) begin
        now_ms = $urandom;
      end else begin
        now_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
      end

      op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
      if (op == OP_PUT) begin
        r = $urandom_range(0, 99);
        if (r < 75)      tmo = TMO_W'($urandom_range(0, 40));
        else if (r < 92) tmo = TMO_W'($urandom_range(0, 5000));
        else             tmo = TMO_W'($urandom);
        // keep deadlines reachable so the queue can still drain
        sum = {1'b0, now_ms} + {2'b00, tmo};
        if (sum[DL_W-1]) tmo = TMO_W'(32'hFFFF_FFFF - now_ms);
      end else begin
        tmo = TMO_W'($urandom);
      end
      send_word(mk_in(op, now_ms, tmo, TAG_W'($urandom)), 0, '0);
    end

    // Empty the queue at the end of time, then run the tail rows.
    calm = 1'b0;
    while (shadow_count > 0)
      send_word(mk_in(OP_GET, 32'hFFFF_FFFF, TMO_W'($urandom), TAG_W'($urandom)), 0, '0);
    walk_rows(tail_start, stim_rows.size());

    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_deadline_sorted_timer_queue_unit passed");
    end else begin
      $display("tb_deadline_sorted_timer_queue_unit failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/dstq_pkg.sv
sv/dstq_cell.sv
sv/deadline_sorted_timer_queue_unit.sv
sim/tb_deadline_sorted_timer_queue_unit.sv
